>>> rtl/core/wrec_pkg.sv
// wrec_pkg: shared constants, codes, item types and helper functions
// for the write range end clamp block; no dependencies
package wrec_pkg;

	// byte shift of one request sector
	localparam int SECTOR_SHIFT_BITS = 9;
	// low device index bits that take part in the compare
	localparam int DEVICE_INDEX_BITS = 10;

	localparam int DEV_W       = 10;
	localparam int SECTOR_W    = 55;
	localparam int LIMIT_W     = 64;
	localparam int SSZ_W       = 16;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_INDEX_W = 2;

	localparam int DEV_CMP_W = (DEVICE_INDEX_BITS < DEV_W) ? DEVICE_INDEX_BITS : DEV_W;
	localparam int BYTE_W    = SECTOR_W + SECTOR_SHIFT_BITS;
	localparam int SUM_W     = LIMIT_W + 1;

	// remainder pipeline: bits of the dividend retired per stage
	localparam int REM_STEP_BITS = 4;
	localparam int REM_STAGES    = LIMIT_W / REM_STEP_BITS;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;
	localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

	localparam logic [SSZ_W-1:0] DEFAULT_SECTOR_BYTES = SSZ_W'(512);

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_LIMIT_DEVICE        = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_LAST_BYTE_LIMIT     = CFG_INDEX_W'(1);
	localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_SECTOR_BYTES = CFG_INDEX_W'(2);

	// verdict codes
	localparam logic [1:0] VERDICT_PASS   = 2'd0;
	localparam logic [1:0] VERDICT_CLAMP  = 2'd1;
	localparam logic [1:0] VERDICT_REJECT = 2'd2;

	typedef struct packed {
		logic                is_write;
		logic [DEV_W-1:0]    device_index;
		logic [SECTOR_W-1:0] start_sector;
		logic [SECTOR_W-1:0] end_sector;
	} req_t;

	typedef struct packed {
		logic [1:0]          verdict;
		logic [SECTOR_W-1:0] new_end_sector;
	} rsp_t;

	// live configuration as seen by the front and back
	typedef struct packed {
		logic [DEV_W-1:0]   limit_device;
		logic [LIMIT_W-1:0] last_byte_limit;
		logic [SSZ_W-1:0]   sector_bytes;
	} cfg_t;

	// classified item handed from front to back
	typedef struct packed {
		logic                bypass;
		logic                reject;
		logic [SECTOR_W-1:0] start_sector;
		logic [SECTOR_W-1:0] end_sector;
		logic [LIMIT_W-1:0]  room;
		logic [SECTOR_W-1:0] len;
	} work_t;

	// one restoring remainder step: shift in one dividend bit
	function automatic logic [SSZ_W-1:0] rem_step(input logic [SSZ_W-1:0] r,
			input logic b, input logic [SSZ_W-1:0] d);
		logic [SSZ_W:0] t;
		t = {r, b};
		if (t >= {1'b0, d}) begin
			t = t - {1'b0, d};
		end
		return t[SSZ_W-1:0];
	endfunction

endpackage

>>> rtl/core/write_range_end_clamp.sv
// write_range_end_clamp: top level with configuration registers, front, queue and back
// depends on wrec_pkg, wrec_front, wrec_fifo, wrec_back
//
// end-of-device write limiter for block requests. each request item carries
// direction, device index and a [start, end) range of 512-byte sectors; one
// response item per request gives a verdict (pass, clamp, reject) and the end
// sector to use. the block takes one request item per clock cycle, steady
// state while the queue has room, and delivers one response per cycle
// while the response side is ready. from request accept to response valid
// an item passes the front stage, which loads at the accept edge, one queue
// slot, the 16-stage remainder pipeline (four bits of the 64-bit byte room
// per stage against the device sector size) and three finishing stages, the
// last of them the output register. a four-entry queue between the front and
// the back lets requests keep arriving while responses are stalled. config
// registers are plain writes (cfg_we, cfg_index, cfg_data) and are expected
// only while no item is in flight; a device sector size of zero acts as 512.
module write_range_end_clamp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [wrec_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [wrec_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  wrec_pkg::req_t                    req,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output wrec_pkg::rsp_t                    rsp
);

	// configuration registers
	logic [wrec_pkg::DEV_W-1:0]   limit_device_q;
	logic [wrec_pkg::LIMIT_W-1:0] last_byte_limit_q;
	logic [wrec_pkg::SSZ_W-1:0]   sector_bytes_q;
	wrec_pkg::cfg_t               cfg;

	// front to queue, queue to back
	logic            front_valid;
	logic            front_ready;
	wrec_pkg::work_t front_item;
	logic            back_valid;
	logic            back_ready;
	wrec_pkg::work_t back_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_device_q    <= '0;
			last_byte_limit_q <= '0;
			sector_bytes_q    <= wrec_pkg::DEFAULT_SECTOR_BYTES;
		end else if (cfg_we) begin
			case (cfg_index)
				wrec_pkg::REG_LIMIT_DEVICE: begin
					limit_device_q <= cfg_data[wrec_pkg::DEV_W-1:0];
				end
				wrec_pkg::REG_LAST_BYTE_LIMIT: begin
					last_byte_limit_q <= cfg_data[wrec_pkg::LIMIT_W-1:0];
				end
				wrec_pkg::REG_DEVICE_SECTOR_BYTES: begin
					sector_bytes_q <= cfg_data[wrec_pkg::SSZ_W-1:0];
				end
				default: begin
					// unmapped index, write dropped
				end
			endcase
		end
	end

	// zero sector size behaves as the default sector
	always_comb begin
		cfg.limit_device    = limit_device_q;
		cfg.last_byte_limit = last_byte_limit_q;
		cfg.sector_bytes    = (sector_bytes_q == '0) ?
			wrec_pkg::DEFAULT_SECTOR_BYTES : sector_bytes_q;
	end

	// classify: bypass, reject, or clamp candidate with room and length
	wrec_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.work_valid (front_valid),
		.work_ready (front_ready),
		.work       (front_item)
	);

	// decouples request intake from response back-pressure
	wrec_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_item  (front_item),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_item   (back_item)
	);

	// remainder, round-up decision and new end sector
	wrec_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.work_valid (back_valid),
		.work_ready (back_ready),
		.work       (back_item),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp)
	);

endmodule

>>> rtl/core/wrec_front.sv
// wrec_front: accepts request items and classifies them against the limit
// depends on wrec_pkg
module wrec_front (
	input  logic           clk,
	input  logic           arst_n,
	input  wrec_pkg::cfg_t cfg,
	input  logic           req_valid,
	output logic           req_ready,
	input  wrec_pkg::req_t req,
	output logic           work_valid,
	input  logic           work_ready,
	output wrec_pkg::work_t work
);

	logic            valid_s1;
	wrec_pkg::work_t work_s1;
	wrec_pkg::work_t work_next;
	logic            load;
	logic            dev_hit;
	logic [wrec_pkg::LIMIT_W-1:0] lim_sectors;
	logic [wrec_pkg::LIMIT_W-1:0] offset;

	assign req_ready  = !valid_s1 || work_ready;
	assign load       = req_valid && req_ready;
	assign work_valid = valid_s1;
	assign work       = work_s1;

	always_comb begin
		dev_hit = req.device_index[wrec_pkg::DEV_CMP_W-1:0] ==
			cfg.limit_device[wrec_pkg::DEV_CMP_W-1:0];
		lim_sectors = cfg.last_byte_limit >> wrec_pkg::SECTOR_SHIFT_BITS;
		offset = wrec_pkg::LIMIT_W'(req.start_sector) << wrec_pkg::SECTOR_SHIFT_BITS;

		work_next.bypass = !req.is_write || (cfg.last_byte_limit == '0) || !dev_hit;
		work_next.reject = wrec_pkg::LIMIT_W'(req.start_sector) > lim_sectors;
		work_next.start_sector = req.start_sector;
		work_next.end_sector   = req.end_sector;
		// bytes left between the write start and the limit
		work_next.room = cfg.last_byte_limit - offset;
		// end below start counts as an empty request
		work_next.len = (req.end_sector >= req.start_sector) ?
			req.end_sector - req.start_sector : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			work_s1 <= work_next;
		end
	end

endmodule

>>> rtl/core/wrec_fifo.sv
// wrec_fifo: short item queue between front and back
// depends on wrec_pkg
module wrec_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  wrec_pkg::work_t push_item,
	output logic            pop_valid,
	input  logic            pop_ready,
	output wrec_pkg::work_t pop_item
);

	wrec_pkg::work_t                 mem_q [wrec_pkg::FIFO_DEPTH];
	logic [wrec_pkg::FIFO_PTR_W-1:0] wr_ptr_q;
	logic [wrec_pkg::FIFO_PTR_W-1:0] rd_ptr_q;
	logic [wrec_pkg::FIFO_CNT_W-1:0] count_q;
	logic                            push;
	logic                            pop;

	assign push_ready = count_q != wrec_pkg::FIFO_CNT_W'(wrec_pkg::FIFO_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_item   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

>>> rtl/core/wrec_back.sv
// wrec_back: remainder pipeline, rounding and new end computation
// depends on wrec_pkg
module wrec_back (
	input  logic            clk,
	input  logic            arst_n,
	input  wrec_pkg::cfg_t  cfg,
	input  logic            work_valid,
	output logic            work_ready,
	input  wrec_pkg::work_t work,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output wrec_pkg::rsp_t  rsp
);

	localparam int LAST = wrec_pkg::REM_STAGES - 1;

	// remainder stages
	logic                          rem_valid_s [wrec_pkg::REM_STAGES];
	wrec_pkg::work_t               rem_work_s  [wrec_pkg::REM_STAGES];
	logic [wrec_pkg::SSZ_W-1:0]    rem_r_s     [wrec_pkg::REM_STAGES];
	logic [wrec_pkg::REM_STAGES-1:0] rem_en;

	// finishing stages
	logic                          fin_valid_s1;
	logic [1:0]                    fin_verdict_s1;
	logic [wrec_pkg::SECTOR_W-1:0] fin_start_s1;
	logic [wrec_pkg::SECTOR_W-1:0] fin_end_s1;
	logic [wrec_pkg::LIMIT_W-1:0]  fin_room_s1;
	logic [wrec_pkg::SSZ_W-1:0]    fin_extra_s1;
	logic [wrec_pkg::BYTE_W-1:0]   fin_diff_s1;

	logic                          fin_valid_s2;
	logic [1:0]                    fin_verdict_s2;
	logic [wrec_pkg::SECTOR_W-1:0] fin_start_s2;
	logic [wrec_pkg::SECTOR_W-1:0] fin_end_s2;
	logic [wrec_pkg::SECTOR_W-1:0] fin_cut_s2;

	logic           rsp_valid_q;
	wrec_pkg::rsp_t rsp_q;

	logic out_en;
	logic s2_en;
	logic s1_en;

	assign out_en     = !rsp_valid_q || rsp_ready;
	assign s2_en      = !fin_valid_s2 || out_en;
	assign s1_en      = !fin_valid_s1 || s2_en;
	assign work_ready = rem_en[0];
	assign rsp_valid  = rsp_valid_q;
	assign rsp        = rsp_q;

	for (genvar k = 0; k < wrec_pkg::REM_STAGES; k++) begin : g_rem
		logic                       v_in;
		wrec_pkg::work_t            w_in;
		logic [wrec_pkg::SSZ_W-1:0] r_in;
		logic [wrec_pkg::SSZ_W-1:0] r_out;

		if (k == 0) begin : g_head
			assign v_in = work_valid;
			assign w_in = work;
			assign r_in = '0;
		end else begin : g_body
			assign v_in = rem_valid_s[k-1];
			assign w_in = rem_work_s[k-1];
			assign r_in = rem_r_s[k-1];
		end

		if (k == LAST) begin : g_en_tail
			assign rem_en[k] = !rem_valid_s[k] || s1_en;
		end else begin : g_en_body
			assign rem_en[k] = !rem_valid_s[k] || rem_en[k+1];
		end

		// retire the next dividend bits, msb first
		always_comb begin
			r_out = r_in;
			for (int b = 0; b < wrec_pkg::REM_STEP_BITS; b++) begin
				r_out = wrec_pkg::rem_step(r_out,
					w_in.room[wrec_pkg::LIMIT_W-1-k*wrec_pkg::REM_STEP_BITS-b],
					cfg.sector_bytes);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rem_valid_s[k] <= 1'b0;
			end else if (rem_en[k]) begin
				rem_valid_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (rem_en[k] && v_in) begin
				rem_work_s[k] <= w_in;
				rem_r_s[k]    <= r_out;
			end
		end
	end

	// first finishing stage: verdict, round-up amount, overshoot room
	wrec_pkg::work_t              last_w;
	logic [wrec_pkg::SSZ_W-1:0]   last_rem;
	logic                         fits;
	logic [1:0]                   verdict_d;
	logic [wrec_pkg::SSZ_W-1:0]   extra_d;
	logic [wrec_pkg::BYTE_W-1:0]  len_bytes;

	assign last_w   = rem_work_s[LAST];
	assign last_rem = rem_r_s[LAST];

	always_comb begin
		fits = wrec_pkg::LIMIT_W'(last_w.len) <=
			(last_w.room >> wrec_pkg::SECTOR_SHIFT_BITS);
		if (last_w.bypass) begin
			verdict_d = wrec_pkg::VERDICT_PASS;
		end else if (last_w.reject) begin
			verdict_d = wrec_pkg::VERDICT_REJECT;
		end else if (fits) begin
			verdict_d = wrec_pkg::VERDICT_PASS;
		end else begin
			verdict_d = wrec_pkg::VERDICT_CLAMP;
		end
		extra_d   = (last_rem != '0) ? cfg.sector_bytes - last_rem : '0;
		len_bytes = wrec_pkg::BYTE_W'(last_w.len) << wrec_pkg::SECTOR_SHIFT_BITS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_valid_s1 <= 1'b0;
		end else if (s1_en) begin
			fin_valid_s1 <= rem_valid_s[LAST];
		end
	end

	always_ff @(posedge clk) begin
		if (s1_en && rem_valid_s[LAST]) begin
			fin_verdict_s1 <= verdict_d;
			fin_start_s1   <= last_w.start_sector;
			fin_end_s1     <= last_w.end_sector;
			fin_room_s1    <= last_w.room;
			fin_extra_s1   <= extra_d;
			// original length minus room, positive whenever clamping
			fin_diff_s1    <= len_bytes - wrec_pkg::BYTE_W'(last_w.room);
		end
	end

	// second finishing stage: rounded cut length in sectors
	logic                        use_extra;
	logic [wrec_pkg::SUM_W-1:0]  cut_bytes;

	always_comb begin
		use_extra = wrec_pkg::BYTE_W'(fin_extra_s1) <= fin_diff_s1;
		cut_bytes = wrec_pkg::SUM_W'(fin_room_s1) +
			(use_extra ? wrec_pkg::SUM_W'(fin_extra_s1) : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_valid_s2 <= 1'b0;
		end else if (s2_en) begin
			fin_valid_s2 <= fin_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_en && fin_valid_s1) begin
			fin_verdict_s2 <= fin_verdict_s1;
			fin_start_s2   <= fin_start_s1;
			fin_end_s2     <= fin_end_s1;
			fin_cut_s2     <= wrec_pkg::SECTOR_W'(cut_bytes >> wrec_pkg::SECTOR_SHIFT_BITS);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_en) begin
			rsp_valid_q <= fin_valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_en && fin_valid_s2) begin
			rsp_q.verdict <= fin_verdict_s2;
			rsp_q.new_end_sector <= (fin_verdict_s2 == wrec_pkg::VERDICT_CLAMP) ?
				fin_start_s2 + fin_cut_s2 : fin_end_s2;
		end
	end

endmodule

>>> rtl/core/wrec_checker.sv
// wrec_checker: port-level checks on the write range end clamp top level
// depends on wrec_pkg; bound to write_range_end_clamp at the end of this file
module wrec_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             cfg_we,
	input logic [wrec_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [wrec_pkg::CFG_DATA_W-1:0]  cfg_data,
	input logic                             req_valid,
	input logic                             req_ready,
	input logic                             rsp_valid,
	input logic                             rsp_ready,
	input wrec_pkg::rsp_t                   rsp
);

	logic       limit_on_q;
	logic [7:0] pending_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_on_q <= 1'b0;
		end else if (cfg_we && (cfg_index == wrec_pkg::REG_LAST_BYTE_LIMIT)) begin
			limit_on_q <= cfg_data != '0;
		end
	end

	// items accepted but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 8'(req_valid && req_ready) - 8'(rsp_valid && rsp_ready);
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	a_verdict_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.verdict == wrec_pkg::VERDICT_PASS) ||
			(rsp.verdict == wrec_pkg::VERDICT_CLAMP) ||
			(rsp.verdict == wrec_pkg::VERDICT_REJECT))
		else $error("response verdict out of range");

	a_limit_off_pass: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !limit_on_q |-> rsp.verdict == wrec_pkg::VERDICT_PASS)
		else $error("clamp or reject with the limit disabled");

	a_no_orphan_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pending_q != '0)
		else $error("response without an outstanding request");

endmodule

bind write_range_end_clamp wrec_checker u_wrec_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_we    (cfg_we),
	.cfg_index (cfg_index),
	.cfg_data  (cfg_data),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

>>> tb/sv/wrec_end_checker.sv
`timescale 1ns / 100ps
// wrec_end_checker: watches the request, response and register ports of the
// write range end clamp block, predicts each response and compares it
// depends on wrec_pkg
module wrec_end_checker
	import wrec_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   req_valid,
	input  logic                   req_ready,
	input  req_t                   req,
	input  logic                   rsp_valid,
	input  logic                   rsp_ready,
	input  rsp_t                   rsp,
	output int                     fail_count,
	output int                     pending,
	output int                     clamps,
	output int                     rejects
);

	// shadow copy of the registers
	logic [DEV_W-1:0]   lim_dev    = '0;
	logic [LIMIT_W-1:0] byte_lim   = '0;
	logic [SSZ_W-1:0]   unit_bytes = DEFAULT_SECTOR_BYTES;

	rsp_t expected_ends[$];
	rsp_t want;

	initial begin
		fail_count = 0;
		pending    = 0;
		clamps     = 0;
		rejects    = 0;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t ns: %s", $time, msg);
		fail_count++;
	endtask

	// verdict and end sector for one request under the shadow registers
	function automatic rsp_t predict_end(input req_t r);
		rsp_t                o;
		logic [SSZ_W-1:0]    unit;
		logic [LIMIT_W-1:0]  room;
		logic [LIMIT_W-1:0]  rem;
		logic [LIMIT_W-1:0]  extra;
		logic [SECTOR_W-1:0] span;
		logic [SUM_W-1:0]    orig_bytes;
		logic [SUM_W-1:0]    cut_bytes;
		logic [SUM_W-1:0]    cut_sectors;
		o.verdict        = VERDICT_PASS;
		o.new_end_sector = r.end_sector;
		unit = (unit_bytes == '0) ? DEFAULT_SECTOR_BYTES : unit_bytes;
		if (!r.is_write || byte_lim == '0 ||
				r.device_index[DEV_CMP_W-1:0] != lim_dev[DEV_CMP_W-1:0]) begin
			return o;
		end
		if (LIMIT_W'(r.start_sector) > (byte_lim >> SECTOR_SHIFT_BITS)) begin
			o.verdict = VERDICT_REJECT;
			return o;
		end
		// start byte fits in 64 bits here since start is at most limit >> shift
		room = byte_lim - (LIMIT_W'(r.start_sector) << SECTOR_SHIFT_BITS);
		span = (r.end_sector >= r.start_sector) ? r.end_sector - r.start_sector : '0;
		if (LIMIT_W'(span) <= (room >> SECTOR_SHIFT_BITS)) begin
			return o;
		end
		orig_bytes = SUM_W'(span) << SECTOR_SHIFT_BITS;
		rem   = room % LIMIT_W'(unit);
		extra = '0;
		if (rem != '0) begin
			extra = LIMIT_W'(unit) - rem;
			// no round up past the original length
			if (SUM_W'(room) + SUM_W'(extra) > orig_bytes) begin
				extra = '0;
			end
		end
		cut_bytes   = SUM_W'(room) + SUM_W'(extra);
		cut_sectors = cut_bytes >> SECTOR_SHIFT_BITS;
		o.verdict        = VERDICT_CLAMP;
		o.new_end_sector = r.start_sector + cut_sectors[SECTOR_W-1:0];
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_dev    = '0;
			byte_lim   = '0;
			unit_bytes = DEFAULT_SECTOR_BYTES;
			expected_ends.delete();
			pending <= 0;
		end else begin
			if (req_valid && req_ready) begin
				expected_ends.push_back(predict_end(req));
			end
			if (rsp_valid && rsp_ready) begin
				if (expected_ends.size() == 0) begin
					report_mismatch($sformatf("response with none expected, verdict %0d end %0h",
						rsp.verdict, rsp.new_end_sector));
				end else begin
					want = expected_ends.pop_front();
					if (rsp.verdict != want.verdict) begin
						report_mismatch($sformatf("verdict %0d, expected %0d",
							rsp.verdict, want.verdict));
					end
					if (rsp.new_end_sector != want.new_end_sector) begin
						report_mismatch($sformatf("end sector %0h, expected %0h",
							rsp.new_end_sector, want.new_end_sector));
					end
					if (want.verdict == VERDICT_CLAMP) begin
						clamps++;
					end
					if (want.verdict == VERDICT_REJECT) begin
						rejects++;
					end
				end
			end
			// register writes land after any request of the same edge
			if (cfg_we) begin
				case (cfg_index)
					REG_LIMIT_DEVICE: begin
						lim_dev = cfg_data[DEV_W-1:0];
					end
					REG_LAST_BYTE_LIMIT: begin
						byte_lim = cfg_data[LIMIT_W-1:0];
					end
					REG_DEVICE_SECTOR_BYTES: begin
						unit_bytes = cfg_data[SSZ_W-1:0];
					end
					default: begin
					end
				endcase
			end
			pending <= expected_ends.size();
		end
	end

endmodule

>>> tb/sv/write_range_end_clamp_tb.sv
`timescale 1ns / 100ps
// write_range_end_clamp_tb: stimulus and verdict for the write range end clamp
// depends on wrec_pkg, write_range_end_clamp and wrec_end_checker
module write_range_end_clamp_tb;
	import wrec_pkg::*;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   req_valid;
	logic                   req_ready;
	req_t                   req;
	logic                   rsp_valid;
	logic                   rsp_ready = 1'b0;
	rsp_t                   rsp;

	int fail_count;
	int pending;
	int clamps;
	int rejects;

	// stimulus side copy of the current settings, used only to aim requests
	logic [DEV_W-1:0]   cur_dev;
	logic [LIMIT_W-1:0] cur_lim;
	logic [SSZ_W-1:0]   cur_ssz;

	// when set, neither side idles
	logic no_idle = 1'b0;
	int   n_sent = 0;
	int   n_settings = 0;

	localparam logic [SECTOR_W-1:0] MAX_SECTOR = '1;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS   = 75;
	localparam int DRAIN_CYCLES  = 30;

	write_range_end_clamp uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	wrec_end_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending),
		.clamps     (clamps),
		.rejects    (rejects)
	);

	initial begin
		clk = 1'b0;
		forever begin
			#5 clk = ~clk;
		end
	end

	// response side stalls about a third of the time, except in the busy stretch
	always @(posedge clk) begin
		rsp_ready <= no_idle || ($urandom_range(0, 99) >= 32);
	end

	// hand one request item to the block; returns right after the accepting edge
	task automatic send_item(input req_t r);
		if (!no_idle) begin
			while ($urandom_range(0, 99) < 32) begin
				req_valid <= 1'b0;
				@(posedge clk);
			end
		end
		req_valid <= 1'b1;
		req       <= r;
		@(posedge clk);
		while (!req_ready) begin
			@(posedge clk);
		end
		n_sent++;
	endtask

	task automatic send_fields(input logic w, input logic [DEV_W-1:0] dev,
			input logic [SECTOR_W-1:0] s, input logic [SECTOR_W-1:0] e);
		req_t r;
		r.is_write     = w;
		r.device_index = dev;
		r.start_sector = s;
		r.end_sector   = e;
		send_item(r);
	endtask

	// drop valid and wait until every expected response is back
	// the first edge lets the count pick up the item accepted last
	task automatic settle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
	endtask

	// write all three registers back to back; only called with the block idle
	task automatic set_limits(input logic [DEV_W-1:0] dev, input logic [LIMIT_W-1:0] lim,
			input logic [SSZ_W-1:0] ssz);
		cur_dev = dev;
		cur_lim = lim;
		cur_ssz = ssz;
		cfg_we    <= 1'b1;
		cfg_index <= REG_LIMIT_DEVICE;
		cfg_data  <= CFG_DATA_W'(dev);
		@(posedge clk);
		cfg_index <= REG_LAST_BYTE_LIMIT;
		cfg_data  <= lim;
		@(posedge clk);
		cfg_index <= REG_DEVICE_SECTOR_BYTES;
		cfg_data  <= CFG_DATA_W'(ssz);
		@(posedge clk);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	function automatic logic [SECTOR_W-1:0] rand_sector();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[SECTOR_W-1:0];
	endfunction

	// random settings: limits from tiny up to the very top of the byte range, or off
	task automatic random_limits();
		logic [DEV_W-1:0]   dev;
		logic [LIMIT_W-1:0] lim;
		logic [SSZ_W-1:0]   ssz;
		dev = DEV_W'($urandom);
		case ($urandom_range(0, 9))
			0, 1: begin
				lim = LIMIT_W'($urandom_range(1, 1 << 20));
			end
			2, 3: begin
				lim = {$urandom, $urandom};
			end
			4, 5: begin
				lim = '1 - LIMIT_W'($urandom_range(0, 200000));
			end
			6: begin
				lim = {$urandom, $urandom} & ~LIMIT_W'(511);
			end
			7: begin
				// clamping off
				lim = '0;
			end
			default: begin
				lim = {24'd0, 8'($urandom), $urandom};
			end
		endcase
		case ($urandom_range(0, 7))
			0: ssz = '0;
			1: ssz = SSZ_W'(1);
			2: ssz = SSZ_W'(512);
			3: ssz = SSZ_W'(4096);
			4: ssz = '1;
			default: ssz = SSZ_W'($urandom);
		endcase
		set_limits(dev, lim, ssz);
	endtask

	// mostly writes to the limited device aimed at the limit, with some noise
	function automatic req_t random_request();
		req_t                r;
		logic [SECTOR_W-1:0] bound;
		logic [SECTOR_W-1:0] span;
		logic [SECTOR_W-1:0] back;
		bound = cur_lim[LIMIT_W-1:SECTOR_SHIFT_BITS];
		span  = rand_sector() >> $urandom_range(0, SECTOR_W - 1);
		r.is_write     = ($urandom_range(0, 99) < 85);
		r.device_index = ($urandom_range(0, 99) < 75) ? cur_dev : DEV_W'($urandom);
		case ($urandom_range(0, 5))
			0: begin
				r.start_sector = rand_sector();
				r.end_sector   = rand_sector();
			end
			1, 2: begin
				// starts a little below the limit and runs some random length
				back = SECTOR_W'($urandom_range(0, 4000));
				r.start_sector = (back > bound) ? '0 : bound - back;
				r.end_sector   = r.start_sector + span;
			end
			3: begin
				// start right around the reject boundary
				r.start_sector = bound + SECTOR_W'($urandom_range(0, 2)) - SECTOR_W'(1);
				r.end_sector   = r.start_sector + span;
			end
			4: begin
				// end right around the limit
				back = SECTOR_W'($urandom_range(0, 1000));
				r.start_sector = (back > bound) ? '0 : bound - back;
				r.end_sector   = bound + SECTOR_W'($urandom_range(0, 3)) - SECTOR_W'(1);
			end
			default: begin
				// end below start; a bound at the top sector already covers every start
				r.start_sector = (bound == MAX_SECTOR) ? rand_sector() :
					rand_sector() % (bound + SECTOR_W'(1));
				r.end_sector   = r.start_sector - SECTOR_W'($urandom_range(1, 100));
			end
		endcase
		return r;
	endfunction

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_LIMIT_DEVICE;
		cfg_data  = '0;
		req_valid = 1'b0;
		req       = '0;
		cur_dev   = '0;
		cur_lim   = '0;
		cur_ssz   = DEFAULT_SECTOR_BYTES;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: limit off, everything passes
		send_fields(1'b1, 10'd0, '0, MAX_SECTOR);
		send_fields(1'b0, 10'd1023, MAX_SECTOR, '0);
		send_fields(1'b1, 10'd0, MAX_SECTOR, MAX_SECTOR);
		settle();

		// limit that is not a sector multiple, 4k device sectors
		set_limits(10'd5, 64'd1_000_000, 16'd4096);
		send_fields(1'b0, 10'd5, 55'd0, 55'd100000);	// read crossing the limit
		send_fields(1'b1, 10'd6, 55'd0, 55'd100000);	// other device
		send_fields(1'b1, 10'd5, 55'd1954, 55'd3000);	// starts past the limit
		send_fields(1'b1, 10'd5, 55'd1953, 55'd1960);	// round up would overshoot
		send_fields(1'b1, 10'd5, 55'd0, 55'd1953);	// ends exactly at the limit sector
		send_fields(1'b1, 10'd5, 55'd0, 55'd1954);	// one sector over
		send_fields(1'b1, 10'd5, 55'd0, 55'd3000);	// cut and rounded up
		send_fields(1'b1, 10'd5, 55'd100, 55'd50);	// end below start
		send_fields(1'b1, 10'd5, 55'd1954, 55'd10);	// end below start, past the limit
		settle();

		// largest limit and device, zero sector size standing for 512
		set_limits(10'd1023, '1, 16'd0);
		send_fields(1'b1, 10'd1023, MAX_SECTOR, MAX_SECTOR);
		send_fields(1'b1, 10'd1023, '0, MAX_SECTOR);
		settle();

		// smallest nonzero limit with the widest sector size
		set_limits(10'd0, 64'd1, 16'hFFFF);
		send_fields(1'b1, 10'd0, 55'd0, 55'd1);
		send_fields(1'b1, 10'd0, 55'd1, 55'd2);
		send_fields(1'b1, 10'd0, 55'd0, MAX_SECTOR);
		settle();

		// room plus round up goes past 64 bits
		set_limits(10'd2, 64'hFFFF_FFFF_FFFF_FC18, 16'd4096);
		send_fields(1'b1, 10'd2, '0, MAX_SECTOR);
		send_fields(1'b1, 10'd2, MAX_SECTOR, MAX_SECTOR);
		settle();

		// one byte sectors: the cut never rounds
		set_limits(10'd7, 64'd777_777, 16'd1);
		send_fields(1'b1, 10'd7, 55'd10, 55'd5000);
		send_fields(1'b1, 10'd7, 55'd1000, 55'd1600);
		settle();

		// random phases, each under fresh settings; one runs with no idling at all
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			random_limits();
			no_idle = (p == 2);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				send_item(random_request());
			end
			settle();
		end
		no_idle = 1'b0;

		// let anything stray show up before the verdict
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		$display("summary: %0d requests under %0d register settings", n_sent, n_settings);
		$display("summary: %0d clamped, %0d rejected, the rest passed unchanged",
			clamps, rejects);
		if (fail_count == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// watchdog far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("timeout with %0d responses outstanding", pending);
		$display("TB_ERROR");
		$finish;
	end

endmodule
